/* rtl/hktr_pkg.sv */
// Package for the hashed key table: payload structs, controller/datapath
// command and status structs, and shared constants.
// No dependencies.
package hktr_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int HASH_W = 32;
    localparam int ID_W   = 6;
    localparam int USE_W  = 16;

    localparam logic [HASH_W-1:0] HASH_MUL = 32'd7723;
    localparam logic [HASH_W-1:0] CHAR_MUL = 32'd9973;

    localparam logic CMD_HASH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] key_hash;
        logic [ID_W-1:0]   entry_id;
        logic [USE_W-1:0]  use_count;
        logic              was_new;
        logic              table_full;
    } out_item_t;

    typedef struct packed {
        logic hash_step;     // fold char into hash; on last char latch key, start search
        logic table_clear;
        logic search_read;   // read key at midpoint
        logic search_update; // narrow bounds from midpoint key
        logic check_read;    // read key/id at lower bound
        logic cnt_read;      // read use count of the hit entry
        logic shift_start;
        logic shift_step;
        logic insert;
        logic cnt_update;
        logic set_full;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic key_below;
        logic hit;
        logic full;
        logic need_shift;
        logic shift_more;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/hktr_ctrl.sv */
// Controller for the hashed key table: sequences hashing, binary search,
// ordered insert and result hand-off. Depends on hktr_pkg.
module hktr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hktr_pkg::in_item_t in_item,
    input  hktr_pkg::dp_stat_t stat,
    output hktr_pkg::dp_cmd_t  cmd
);
    import hktr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;
    localparam logic [2:0] ST_COUNT  = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.command == CMD_CLEAR)
                    begin
                        cmd.table_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.hash_step = 1'b1;
                        if (in_item.last_char)
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.search_read = 1'b1;
                    state_next      = ST_PROBE;
                end
                else
                begin
                    cmd.check_read = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_PROBE:
            begin
                cmd.search_update = 1'b1;
                state_next        = ST_SEARCH;
            end
            ST_CHECK:
            begin
                priority if (stat.hit)
                begin
                    cmd.cnt_read = 1'b1;
                    state_next   = ST_COUNT;
                end
                else if (stat.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_RESULT;
                end
                else if (stat.need_shift)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (!stat.shift_more)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_RESULT;
            end
            ST_COUNT:
            begin
                cmd.cnt_update = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/hktr_datapath.sv */
// Datapath for the hashed key table: running hash, search bounds, the
// sorted key/id memories, the use-count memory and the output register.
// Depends on hktr_pkg.
module hktr_datapath #(
    parameter int TABLE_DEPTH = hktr_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = hktr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hktr_pkg::in_item_t  in_item,
    input  hktr_pkg::dp_cmd_t   cmd,
    output hktr_pkg::dp_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output hktr_pkg::out_item_t out_item
);
    import hktr_pkg::*;

    localparam int IDW  = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);

    // storage
    logic [HASH_W-1:0]      key_mem [TABLE_DEPTH];
    logic [IDW-1:0]         id_mem  [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

    logic [HASH_W-1:0]      hash_reg;
    logic [HASH_W-1:0]      key_reg;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        lo_reg;
    logic [CNTW-1:0]        hi_reg;
    logic [IDW-1:0]         mid_reg;
    logic [IDW-1:0]         wptr_reg;
    logic [IDW-1:0]         hit_id_reg;
    logic [HASH_W-1:0]      key_rdata_reg;
    logic [IDW-1:0]         id_rdata_reg;
    logic [COUNT_WIDTH-1:0] cnt_rdata_reg;
    logic [IDW-1:0]         res_id_reg;
    logic [COUNT_WIDTH-1:0] res_cnt_reg;
    logic                   res_new_reg;
    logic                   res_full_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic [HASH_W-1:0]      char_sext;
    logic [HASH_W-1:0]      hash_new;
    logic [CNTW:0]          mid_sum;
    logic [IDW-1:0]         mid;
    logic [CNTW-1:0]        count_m1;
    logic [CNTW:0]          lo_p1;
    logic [IDW-1:0]         rd_addr;
    logic                   kw_en;
    logic [IDW-1:0]         kw_addr;
    logic [HASH_W-1:0]      kw_key;
    logic [IDW-1:0]         kw_id;
    logic                   cw_en;
    logic [IDW-1:0]         cw_addr;
    logic [COUNT_WIDTH-1:0] cw_data;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    logic [IDW+ID_W-1:0]    id_wide;
    logic [COUNT_WIDTH+USE_W-1:0] cnt_wide;

    assign char_sext = {{(HASH_W-8){in_item.char_code[7]}}, in_item.char_code};
    assign hash_new  = (hash_reg * HASH_MUL) ^ (char_sext * CHAR_MUL);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDW:1];
    assign count_m1 = count_reg - 1'b1;
    assign lo_p1    = {1'b0, lo_reg} + 1'b1;

    assign cnt_sat = (cnt_rdata_reg == '1) ? cnt_rdata_reg : cnt_rdata_reg + 1'b1;

    assign stat.lo_lt_hi   = (lo_reg < hi_reg);
    assign stat.key_below  = (key_rdata_reg < key_reg);
    assign stat.hit        = (lo_reg != count_reg) && (key_rdata_reg == key_reg);
    assign stat.full       = (count_reg == DEPTH_C);
    assign stat.need_shift = (count_reg != lo_reg);
    assign stat.shift_more = ({{(CNTW+1-IDW){1'b0}}, wptr_reg} > lo_p1);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // shared read address of the key/id memories
    always_comb
    begin
        priority if (cmd.search_read)
        begin
            rd_addr = mid;
        end
        else if (cmd.shift_start)
        begin
            rd_addr = count_m1[IDW-1:0];
        end
        else if (cmd.shift_step)
        begin
            rd_addr = wptr_reg - IDW'(2);
        end
        else
        begin
            rd_addr = lo_reg[IDW-1:0];
        end
    end

    always_comb
    begin
        kw_en   = cmd.shift_step || cmd.insert;
        kw_addr = lo_reg[IDW-1:0];
        kw_key  = key_reg;
        kw_id   = count_reg[IDW-1:0];
        if (cmd.shift_step)
        begin
            kw_addr = wptr_reg;
            kw_key  = key_rdata_reg;
            kw_id   = id_rdata_reg;
        end
    end

    always_comb
    begin
        cw_en   = cmd.insert || cmd.cnt_update;
        cw_addr = count_reg[IDW-1:0];
        cw_data = COUNT_WIDTH'(1);
        if (cmd.cnt_update)
        begin
            cw_addr = hit_id_reg;
            cw_data = cnt_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= kw_key;
            id_mem[kw_addr]  <= kw_id;
        end
        key_rdata_reg <= key_mem[rd_addr];
        id_rdata_reg  <= id_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cnt_mem[cw_addr] <= cw_data;
        end
        cnt_rdata_reg <= cnt_mem[id_rdata_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.table_clear)
            begin
                hash_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                hash_reg <= in_item.last_char ? '0 : hash_new;
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.hash_step && in_item.last_char)
        begin
            key_reg <= hash_new;
            lo_reg  <= '0;
            hi_reg  <= count_reg;
        end
        if (cmd.search_read)
        begin
            mid_reg <= mid;
        end
        if (cmd.search_update)
        begin
            if (stat.key_below)
            begin
                lo_reg <= CNTW'(mid_reg) + 1'b1;
            end
            else
            begin
                hi_reg <= CNTW'(mid_reg);
            end
        end
        if (cmd.shift_start)
        begin
            wptr_reg <= count_reg[IDW-1:0];
        end
        else if (cmd.shift_step)
        begin
            wptr_reg <= wptr_reg - 1'b1;
        end
        if (cmd.cnt_read)
        begin
            hit_id_reg <= id_rdata_reg;
        end
        if (cmd.insert)
        begin
            res_id_reg   <= count_reg[IDW-1:0];
            res_cnt_reg  <= COUNT_WIDTH'(1);
            res_new_reg  <= 1'b1;
            res_full_reg <= 1'b0;
        end
        else if (cmd.cnt_update)
        begin
            res_id_reg   <= hit_id_reg;
            res_cnt_reg  <= cnt_sat;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else if (cmd.set_full)
        begin
            res_id_reg   <= '0;
            res_cnt_reg  <= '0;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_reg.key_hash   <= key_reg;
            out_reg.entry_id   <= id_wide[ID_W-1:0];
            out_reg.use_count  <= cnt_wide[USE_W-1:0];
            out_reg.was_new    <= res_new_reg;
            out_reg.table_full <= res_full_reg;
        end
    end

    assign id_wide  = {{ID_W{1'b0}}, res_id_reg};
    assign cnt_wide = {{USE_W{1'b0}}, res_cnt_reg};

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* rtl/hashed_key_table_refcount.sv */
// Top level of the hashed key table with use counts: controller plus
// datapath. Depends on hktr_pkg, hktr_ctrl and hktr_datapath.
//
// Names arrive one character per transfer and, while no lookup is in
// progress, are hashed at one character per cycle (hash = hash*7723 ^
// sext(char)*9973, mod 2^32). The transfer marked last_char triggers a
// lookup in a sorted table of TABLE_DEPTH keys and yields one result;
// other characters and the clear command yield none. A lookup runs the
// binary-search probes (at most ceil(log2(N+1)) for N stored keys), then
// reads and checks the lower-bound entry. A hit then updates the use
// count, a full table adds nothing, and an insert at position pos moves
// the N-pos entries above it one per cycle through the single write port
// of the key memory, then writes the new key. The result goes to the
// output register once that register is free or being accepted. A
// finished result waits in the output register while the next name is
// taken. The memories need no clearing pass after reset.
module hashed_key_table_refcount #(
    parameter int TABLE_DEPTH = hktr_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = hktr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hktr_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hktr_pkg::out_item_t out_item
);
    import hktr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hktr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .stat     (stat),
        .cmd      (cmd)
    );

    hktr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* test/hktr_lookup_checker.sv */
`timescale 1ns / 100ps
// Checker for the hashed key table: watches the input and result channels,
// keeps its own sorted key table and use counts, and compares each result.
// Depends on hktr_pkg for the payload structs and command codes.
module hktr_lookup_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  hktr_pkg::in_item_t  in_item,
    output int                  mismatches,
    output int                  pending,
    input  logic                out_valid,
    input  logic                out_ready,
    input  hktr_pkg::out_item_t out_item
);
    import hktr_pkg::*;

    localparam int          DEPTH     = 64;
    localparam logic [31:0] MUL_HASH  = 32'd7723;
    localparam logic [31:0] MUL_CHAR  = 32'd9973;
    localparam logic [15:0] USE_MAX   = 16'hFFFF;

    logic [31:0] name_hash;
    logic [31:0] key_sorted [DEPTH];
    logic [5:0]  id_sorted  [DEPTH];
    logic [15:0] uses       [DEPTH];
    int          n_keys;
    out_item_t   lookups_due [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h",
                 $time, what, got, want);
        mismatches++;
    endtask

    // Fold one accepted transfer into the running hash; on the last
    // character, search/insert and queue the lookup result.
    task automatic fold_char(input in_item_t it);
        logic [31:0] ext;
        logic [31:0] key;
        int          lo;
        int          hi;
        int          mid;
        int          pos;
        int          k;
        out_item_t   r;
        if (it.command == CMD_CLEAR)
        begin
            n_keys    = 0;
            name_hash = '0;
        end
        else
        begin
            ext       = {{24{it.char_code[7]}}, it.char_code};
            name_hash = (name_hash * MUL_HASH) ^ (ext * MUL_CHAR);
            if (it.last_char)
            begin
                key       = name_hash;
                name_hash = '0;
                lo        = 0;
                hi        = n_keys;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (key_sorted[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                pos        = lo;
                r          = '0;
                r.key_hash = key;
                if (pos < n_keys && key_sorted[pos] == key)
                    r.entry_id = id_sorted[pos];
                else if (n_keys >= DEPTH)
                    r.table_full = 1'b1;
                else
                begin
                    for (k = n_keys; k > pos; k--)
                    begin
                        key_sorted[k] = key_sorted[k-1];
                        id_sorted[k]  = id_sorted[k-1];
                    end
                    key_sorted[pos] = key;
                    id_sorted[pos]  = 6'(n_keys);
                    uses[n_keys]    = '0;
                    r.entry_id      = 6'(n_keys);
                    r.was_new       = 1'b1;
                    n_keys++;
                end
                if (!r.table_full)
                begin
                    if (uses[r.entry_id] != USE_MAX)
                        uses[r.entry_id]++;
                    r.use_count = uses[r.entry_id];
                end
                lookups_due.insert(lookups_due.size(), r);
            end
        end
    endtask

    task automatic check_lookup(input out_item_t got);
        out_item_t want;
        if (lookups_due.size() == 0)
            flag_mismatch("result with none expected", got.key_hash, '0);
        else
        begin
            want = lookups_due.pop_front();
            if (got.key_hash !== want.key_hash)
                flag_mismatch("key_hash", got.key_hash, want.key_hash);
            if (got.entry_id !== want.entry_id)
                flag_mismatch("entry_id", 32'(got.entry_id), 32'(want.entry_id));
            if (got.use_count !== want.use_count)
                flag_mismatch("use_count", 32'(got.use_count), 32'(want.use_count));
            if (got.was_new !== want.was_new)
                flag_mismatch("was_new", 32'(got.was_new), 32'(want.was_new));
            if (got.table_full !== want.table_full)
                flag_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_hash  = '0;
            n_keys     = 0;
            mismatches = 0;
            lookups_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_lookup(out_item);
            if (in_valid && in_ready)
                fold_char(in_item);
        end
        pending = lookups_due.size();
    end

endmodule

/* test/tb_hashed_key_table_refcount.sv */
`timescale 1ns / 100ps
// Testbench top for hashed_key_table_refcount: clock, reset, name stimulus,
// receiver stall patterns, watchdog and verdict. Depends on hktr_pkg, the
// block itself and hktr_lookup_checker.
module tb_hashed_key_table_refcount;
    import hktr_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 540;
    localparam int HIT_ROUNDS   = 70;
    localparam int DICT_SIZE    = 20;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    int        mismatches;
    int        pending;

    logic       steady_rx;
    logic       hold_req;
    logic       gapless;
    int         burst_left;
    int         items_sent;
    int         idle_cycles = 0;
    logic [7:0] name_buf [$];
    logic [7:0] dict_chars [DICT_SIZE][6];
    int         dict_len [DICT_SIZE];
    logic [7:0] perm [256];

    hashed_key_table_refcount dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    hktr_lookup_checker lookup_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .mismatches (mismatches),
        .pending    (pending),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_hashed_key_table_refcount failed");
                $finish;
            end
        end
    end

    // Receiver: random segments of differing ready patterns, one long hold-off.
    initial
    begin : rx_pattern
        int       seg;
        int       k;
        logic     held;
        rx_mode_t mode;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            seg  = $urandom_range(80, 16);
            mode = rx_mode_t'($urandom_range(3, 0));
            for (k = 0; k < seg; k++)
            begin
                @(negedge clk);
                if (hold_req && !held)
                begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end
                else if (steady_rx)
                    out_ready <= 1'b1;
                else
                    case (mode)
                        RX_OPEN:   out_ready <= 1'b1;
                        RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
                        RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
                        default:   out_ready <= k[2];
                    endcase
            end
        end
    end

    function automatic in_item_t mk(input logic cmd, input logic [7:0] c,
                                    input logic last);
        in_item_t it;
        it.command   = cmd;
        it.char_code = c;
        it.last_char = last;
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then apply the burst/gap pacing.
    task automatic push_item(input in_item_t it);
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (!gapless)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(16, 1);
                repeat ($urandom_range(12, 1))
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    in_item  <= in_item_t'(10'($urandom));
                end
            end
        end
    endtask

    task automatic send_name();
        int k;
        for (k = 0; k < name_buf.size(); k++)
            push_item(mk(CMD_HASH, name_buf[k], k == name_buf.size() - 1));
    endtask

    initial
    begin : stimulus
        int         k;
        int         j;
        int         e;
        int         roll;
        int         pick;
        int         random_base;
        logic [7:0] tmp;
        logic [7:0] extremes [4];

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        steady_rx  = 1'b0;
        hold_req   = 1'b0;
        gapless    = 1'b0;
        burst_left = 0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: sign extension, zero byte, hits, clear mid-name
        push_item(mk(CMD_HASH, 8'h41, 1'b1));
        push_item(mk(CMD_HASH, 8'h41, 1'b1));
        push_item(mk(CMD_HASH, 8'h00, 1'b1));
        push_item(mk(CMD_HASH, 8'hFF, 1'b1));
        push_item(mk(CMD_HASH, 8'h80, 1'b1));
        push_item(mk(CMD_HASH, 8'h7F, 1'b1));
        name_buf = '{8'h12, 8'hFE, 8'h00, 8'h80};
        send_name();
        send_name();
        push_item(mk(CMD_HASH, 8'h00, 1'b0));
        push_item(mk(CMD_HASH, 8'h00, 1'b1));
        push_item(mk(CMD_CLEAR, 8'hFF, 1'b1));
        push_item(mk(CMD_HASH, 8'hC3, 1'b0));
        push_item(mk(CMD_CLEAR, 8'h00, 1'b0));
        push_item(mk(CMD_HASH, 8'h41, 1'b1));
        push_item(mk(CMD_HASH, 8'hFF, 1'b1));

        // fill the table with single-char keys in random order, then overflow
        for (k = 0; k < 256; k++)
            perm[k] = 8'(k);
        for (k = 255; k > 0; k--)
        begin
            j       = $urandom_range(k, 0);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        extremes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        for (e = 0; e < 4; e++)
            for (k = 0; k < 256; k++)
                if (perm[k] == extremes[e])
                begin
                    perm[k]      = perm[e * 16];
                    perm[e * 16] = extremes[e];
                end
        push_item(mk(CMD_CLEAR, 8'h00, 1'b0));
        for (k = 0; k < 67; k++)
            push_item(mk(CMD_HASH, perm[k], 1'b1));
        push_item(mk(CMD_HASH, perm[10], 1'b1));
        push_item(mk(CMD_HASH, perm[70], 1'b1));
        push_item(mk(CMD_HASH, perm[63], 1'b1));

        // repeated hits on one key, at full speed
        push_item(mk(CMD_CLEAR, 8'h00, 1'b0));
        steady_rx = 1'b1;
        gapless   = 1'b1;
        repeat (HIT_ROUNDS)
            push_item(mk(CMD_HASH, 8'h5A, 1'b1));
        steady_rx = 1'b0;
        gapless   = 1'b0;
        push_item(mk(CMD_CLEAR, 8'h00, 1'b1));

        // random: mostly names from a small dictionary so keys repeat
        for (k = 0; k < DICT_SIZE; k++)
        begin
            dict_len[k] = (k == 0) ? 1 : $urandom_range(5, 1);
            for (j = 0; j < 6; j++)
                dict_chars[k][j] = 8'($urandom);
        end
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            if (items_sent - random_base >= 40)
                hold_req = 1'b1;
            roll = $urandom_range(99, 0);
            if (roll < 1)
                push_item(mk(CMD_CLEAR, 8'($urandom), 1'($urandom)));
            else if (roll < 5)
            begin
                // partial name dropped by a clear
                repeat ($urandom_range(3, 1))
                    push_item(mk(CMD_HASH, 8'($urandom), 1'b0));
                push_item(mk(CMD_CLEAR, 8'($urandom), 1'($urandom)));
            end
            else if (roll < 75)
            begin
                pick = $urandom_range(DICT_SIZE - 1, 0);
                name_buf.delete();
                for (j = 0; j < dict_len[pick]; j++)
                    name_buf.insert(name_buf.size(), dict_chars[pick][j]);
                send_name();
            end
            else
            begin
                name_buf.delete();
                repeat ($urandom_range(6, 1))
                    name_buf.insert(name_buf.size(), 8'($urandom));
                send_name();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_hashed_key_table_refcount passed");
        else
            $display("tb_hashed_key_table_refcount failed");
        $finish;
    end

endmodule
